FILE: src/wfsr_pkg.sv
// ----------------------------------------------------------------------------
// wfsr_pkg
// Shared request codes and force limits for the wheel force step regulator.
// ----------------------------------------------------------------------------
package wfsr_pkg;

  typedef enum logic [1:0] {
    REQ_SAMPLE   = 2'd0,
    REQ_SETPOINT = 2'd1,
    REQ_HALT     = 2'd2
  } req_e;

  localparam int unsigned ForceW = 8;
  localparam int unsigned RateW  = 16;

  // internal force math runs one bit wider so a step past the limit is visible
  localparam logic signed [ForceW:0] ForceMax  = 9'sd100;
  localparam logic signed [ForceW:0] ForceKick = 9'sd30;
  localparam logic signed [ForceW:0] ForceStep = 9'sd1;

endpackage

FILE: src/wfsr_step.sv
// ----------------------------------------------------------------------------
// wfsr_step
// One bang-bang step of a wheel force toward its setpoint, with dead-band
// jumps and snaps, clamp to +/-ForceMax and forced zero cases.
// ----------------------------------------------------------------------------
module wfsr_step (
  input  logic signed [wfsr_pkg::ForceW-1:0] force_i,
  input  logic signed [wfsr_pkg::RateW-1:0]  rate_i,
  input  logic signed [wfsr_pkg::RateW-1:0]  target_i,
  input  logic                               halt_i,
  output logic signed [wfsr_pkg::ForceW-1:0] force_o
);

  logic signed [wfsr_pkg::ForceW:0] f;
  logic signed [wfsr_pkg::ForceW:0] n_up;
  logic signed [wfsr_pkg::ForceW:0] n_dn;
  logic signed [wfsr_pkg::ForceW:0] stepped;
  logic signed [wfsr_pkg::ForceW:0] clamped;
  logic                             f_zero;
  logic                             r_zero;

  assign f      = {force_i[wfsr_pkg::ForceW-1], force_i};
  assign n_up   = f + wfsr_pkg::ForceStep;
  assign n_dn   = f - wfsr_pkg::ForceStep;
  assign f_zero = (force_i == '0);
  assign r_zero = (rate_i == '0);

  always_comb begin
    stepped = f;
    if (rate_i < target_i) begin
      if (f_zero) begin
        if (r_zero) begin
          stepped = n_up;
        end
      end else if (n_up < -wfsr_pkg::ForceKick) begin
        stepped = '0;
      end else if ((n_up < wfsr_pkg::ForceKick) && (n_up > 0)) begin
        stepped = wfsr_pkg::ForceKick;
      end else begin
        stepped = n_up;
      end
    end else if (rate_i > target_i) begin
      if (f_zero) begin
        if (r_zero) begin
          stepped = n_dn;
        end
      end else if ((n_dn < wfsr_pkg::ForceKick) && (n_dn > 0)) begin
        stepped = '0;
      end else if (n_dn < -wfsr_pkg::ForceKick) begin
        stepped = -wfsr_pkg::ForceKick;
      end else begin
        stepped = n_dn;
      end
    end
  end

  always_comb begin
    if (stepped > wfsr_pkg::ForceMax) begin
      clamped = wfsr_pkg::ForceMax;
    end else if (stepped < -wfsr_pkg::ForceMax) begin
      clamped = -wfsr_pkg::ForceMax;
    end else begin
      clamped = stepped;
    end
    if ((target_i == '0 && r_zero) || halt_i) begin
      clamped = '0;
    end
  end

  assign force_o = clamped[wfsr_pkg::ForceW-1:0];

endmodule

FILE: src/wheel_force_step_regulator.sv
// ----------------------------------------------------------------------------
// wheel_force_step_regulator
// Two-wheel bang-bang force regulator driven by rate samples.
// ----------------------------------------------------------------------------
// Takes one word per clock cycle while not stalled. Each word passes an input
// register and is then applied: setpoint and stop writes update the stored
// state, a rate sample steps that wheel's force and loads the result register,
// from which the result word is presented downstream.
// Per-wheel force and setpoint live in flip-flops read and written in the same
// cycle, so samples for the same wheel may follow back to back. Words with an
// unused request code are dropped. Input stalls only while a result waits
// downstream and the next word is a rate sample.
module wheel_force_step_regulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // wheel[0], value[16:1], zero pad
  input  logic [1:0]  s_axis_tuser_i,  // req_type[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // wheel_out[0], force_res[8:1], zero pad
);

  // input register
  logic                              in_valid_q;
  logic [1:0]                        in_type_q;
  logic                              in_wheel_q;
  logic signed [wfsr_pkg::RateW-1:0] in_value_q;

  // state
  logic signed [wfsr_pkg::ForceW-1:0] force_q  [2];
  logic signed [wfsr_pkg::RateW-1:0]  target_q [2];
  logic                               halt_q;

  // result register
  logic                               out_valid_q;
  logic                               out_wheel_q;
  logic signed [wfsr_pkg::ForceW-1:0] out_force_q;

  logic                               is_sample;
  logic                               out_free;
  logic                               advance;
  logic                               s_fire;
  logic signed [wfsr_pkg::ForceW-1:0] force_d;

  assign is_sample = (in_type_q == wfsr_pkg::REQ_SAMPLE);
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign advance   = in_valid_q && (!is_sample || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_fire    = s_axis_tvalid_i && s_axis_tready_o;

  wfsr_step u_step (
    .force_i  (force_q[in_wheel_q]),
    .rate_i   (in_value_q),
    .target_i (target_q[in_wheel_q]),
    .halt_i   (halt_q),
    .force_o  (force_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_type_q  <= s_axis_tuser_i;
      in_wheel_q <= s_axis_tdata_i[0];
      in_value_q <= s_axis_tdata_i[16:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_q[0]  <= '0;
      force_q[1]  <= '0;
      target_q[0] <= '0;
      target_q[1] <= '0;
      halt_q      <= 1'b0;
    end else if (advance) begin
      case (in_type_q)
        wfsr_pkg::REQ_SAMPLE:   force_q[in_wheel_q]  <= force_d;
        wfsr_pkg::REQ_SETPOINT: target_q[in_wheel_q] <= in_value_q;
        wfsr_pkg::REQ_HALT:     halt_q               <= in_value_q[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && is_sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_sample) begin
      out_wheel_q <= in_wheel_q;
      out_force_q <= force_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_force_q, out_wheel_q};

endmodule
